// File: src/gtp_pkg.sv
// Shared types and constants for the Goertzel tone power detector.
package gtp_pkg;

    // Field and datapath widths.
    localparam int FRAC_BITS = 14;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 17;
    localparam int DELAY_W   = 40;
    localparam int HALF_W    = 20;
    localparam int OPA_W     = DELAY_W;
    localparam int OPB_W     = HALF_W + 1;
    localparam int MUL_W     = OPA_W + OPB_W;
    localparam int PROD2_W   = 2 * DELAY_W;
    localparam int ACC_W     = 98;
    localparam int REC_W     = 48;
    localparam int POWER_W   = 63;
    localparam int STEP_W    = 4;

    // Last step of the power sequence.
    localparam logic [STEP_W-1:0] PWR_LAST = 4'd11;

    // Saturation bounds of the delay line.
    localparam logic signed [REC_W-1:0] DELAY_MAX = 48'sd549755813887;
    localparam logic signed [REC_W-1:0] DELAY_MIN = -48'sd549755813888;

    // Rounding offset that turns the final shift into a floor of the subtracted term.
    localparam logic signed [ACC_W-1:0] ROUND_OFFSET = ACC_W'((1 << FRAC_BITS) - 1);

    // Saturated power.
    localparam logic [POWER_W-1:0] POWER_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC_MUL,
        ST_REC_UPD,
        ST_PWR,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        A_S1,
        A_S2,
        A_COEF
    } a_sel_t;

    typedef enum logic [3:0] {
        B_S1_LO,
        B_S1_HI,
        B_S2_LO,
        B_S2_HI,
        B_COEF,
        B_M0,
        B_M1,
        B_M2,
        B_M3
    } b_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ROUND,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        SH_0,
        SH_14,
        SH_20,
        SH_34,
        SH_40,
        SH_60
    } acc_sh_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        acc_sh_t acc_sh;
        logic    upd_delay;
        logic    clr_delay;
        logic    m_load;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_end;
    } dp_status_t;

endpackage

// File: src/gtp_datapath.sv
// Datapath: coefficient, delay line, shared multiplier, accumulator and result word.
module gtp_datapath import gtp_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic signed [COEF_W-1:0]   cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic                       s_block_end,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    output logic [POWER_W-1:0]         m_tone_power
);

    logic signed [COEF_W-1:0]   coef_reg;
    logic signed [DELAY_W-1:0]  s1_reg;
    logic signed [DELAY_W-1:0]  s2_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       end_reg;
    logic signed [MUL_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PROD2_W-1:0]  m_reg;
    logic [POWER_W-1:0]         power_reg;
    logic [POWER_W-1:0]         power_next;

    logic signed [OPA_W-1:0]    a_op;
    logic signed [OPB_W-1:0]    b_op;
    logic signed [MUL_W-1:0]    mul_res;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    addend;
    logic signed [REC_W-1:0]    rec_sum;
    logic signed [DELAY_W-1:0]  rec_sat;

    // The coefficient register is written directly from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            coef_reg <= cfg_wr_data;
        end
    end

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg <= 1'b0;
        end else if (cmd.load_in) begin
            end_reg <= s_block_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg <= s_sample_value;
        end
    end

    assign status.block_end = end_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.a_sel)
            A_S1:    a_op = s1_reg;
            A_S2:    a_op = s2_reg;
            A_COEF:  a_op = {{(OPA_W - COEF_W){coef_reg[COEF_W-1]}}, coef_reg};
            default: a_op = s1_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.b_sel)
            B_S1_LO: b_op = {1'b0, s1_reg[HALF_W-1:0]};
            B_S1_HI: b_op = {s1_reg[DELAY_W-1], s1_reg[DELAY_W-1:HALF_W]};
            B_S2_LO: b_op = {1'b0, s2_reg[HALF_W-1:0]};
            B_S2_HI: b_op = {s2_reg[DELAY_W-1], s2_reg[DELAY_W-1:HALF_W]};
            B_COEF:  b_op = {{(OPB_W - COEF_W){coef_reg[COEF_W-1]}}, coef_reg};
            B_M0:    b_op = {1'b0, m_reg[HALF_W-1:0]};
            B_M1:    b_op = {1'b0, m_reg[2*HALF_W-1:HALF_W]};
            B_M2:    b_op = {1'b0, m_reg[3*HALF_W-1:2*HALF_W]};
            B_M3:    b_op = {m_reg[PROD2_W-1], m_reg[PROD2_W-1:3*HALF_W]};
            default: b_op = {1'b0, s1_reg[HALF_W-1:0]};
        endcase
    end

    // One 40 x 21 signed multiply per cycle, registered when the multiply enable is set.
    assign mul_res = a_op * b_op;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_res;
        end
    end

    // Recurrence: s = x + floor(c * s1 / 2^14) - s2, saturated to the delay width.
    assign rec_sum = REC_W'(x_reg) + REC_W'(prod_reg >>> FRAC_BITS) - REC_W'(s2_reg);

    always_comb begin
        priority if (rec_sum > DELAY_MAX) begin
            rec_sat = DELAY_MAX[DELAY_W-1:0];
        end else if (rec_sum < DELAY_MIN) begin
            rec_sat = DELAY_MIN[DELAY_W-1:0];
        end else begin
            rec_sat = rec_sum[DELAY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (cmd.clr_delay) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (cmd.upd_delay) begin
            s1_reg <= rec_sat;
            s2_reg <= s1_reg;
        end
    end

    // Partial products are placed by a fixed shift and summed modulo 2^ACC_W;
    // the final value always fits, so wraparound in between is harmless.
    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        unique case (cmd.acc_sh)
            SH_0:    addend = prod_ext;
            SH_14:   addend = prod_ext <<< FRAC_BITS;
            SH_20:   addend = prod_ext <<< HALF_W;
            SH_34:   addend = prod_ext <<< (HALF_W + FRAC_BITS);
            SH_40:   addend = prod_ext <<< (2 * HALF_W);
            SH_60:   addend = prod_ext <<< (3 * HALF_W);
            default: addend = prod_ext;
        endcase
    end

    always_comb begin
        unique case (cmd.acc_op)
            ACC_HOLD:  acc_next = acc_reg;
            ACC_CLEAR: acc_next = '0;
            ACC_ROUND: acc_next = ROUND_OFFSET;
            ACC_ADD:   acc_next = acc_reg + addend;
            ACC_SUB:   acc_next = acc_reg - addend;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // The cross product s1*s2 is kept for the coefficient pass.
    always_ff @(posedge aclk) begin
        if (cmd.m_load) begin
            m_reg <= acc_reg[PROD2_W-1:0];
        end
    end

    // Final shift by 14, clamp at zero and saturate to 63 bits.
    always_comb begin
        priority if (acc_reg[ACC_W-1]) begin
            power_next = '0;
        end else if (|acc_reg[ACC_W-2:FRAC_BITS+POWER_W]) begin
            power_next = POWER_MAX;
        end else begin
            power_next = acc_reg[FRAC_BITS+POWER_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            power_reg <= power_next;
        end
    end

    assign m_tone_power = power_reg;

endmodule

// File: src/gtp_ctrl.sv
// Controller: sequences the recurrence and the power computation, owns the handshakes.
module gtp_ctrl import gtp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    // The result register can take a new word when empty or being drained now.
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and step count.
    always_comb begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_REC_MUL;
                end
            end
            ST_REC_MUL: begin
                state_next = ST_REC_UPD;
            end
            ST_REC_UPD: begin
                state_next = status.block_end ? ST_PWR : ST_IDLE;
            end
            ST_PWR: begin
                if (step_reg == PWR_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid tracks loads and accepted words.
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign s_ready = (state_reg == ST_IDLE);

    // Datapath commands per state and power step.
    always_comb begin
        cmd           = '0;
        cmd.a_sel     = A_S1;
        cmd.b_sel     = B_COEF;
        cmd.acc_op    = ACC_HOLD;
        cmd.acc_sh    = SH_0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_valid;
            end
            ST_REC_MUL: begin
                cmd.mul_en = 1'b1;
            end
            ST_REC_UPD: begin
                cmd.upd_delay = 1'b1;
            end
            ST_PWR: begin
                unique case (step_reg)
                    4'd0: begin
                        cmd.mul_en = 1'b1;
                        cmd.b_sel  = B_S2_LO;
                        cmd.acc_op = ACC_CLEAR;
                    end
                    4'd1: begin
                        cmd.mul_en = 1'b1;
                        cmd.b_sel  = B_S2_HI;
                        cmd.acc_op = ACC_ADD;
                    end
                    4'd2: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = SH_20;
                    end
                    4'd3: begin
                        cmd.m_load = 1'b1;
                        cmd.acc_op = ACC_ROUND;
                        cmd.mul_en = 1'b1;
                        cmd.b_sel  = B_S1_LO;
                    end
                    4'd4: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = SH_14;
                        cmd.mul_en = 1'b1;
                        cmd.b_sel  = B_S1_HI;
                    end
                    4'd5: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = SH_34;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_S2;
                        cmd.b_sel  = B_S2_LO;
                    end
                    4'd6: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = SH_14;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_S2;
                        cmd.b_sel  = B_S2_HI;
                    end
                    4'd7: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = SH_34;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_COEF;
                        cmd.b_sel  = B_M0;
                    end
                    4'd8: begin
                        cmd.acc_op = ACC_SUB;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_COEF;
                        cmd.b_sel  = B_M1;
                    end
                    4'd9: begin
                        cmd.acc_op = ACC_SUB;
                        cmd.acc_sh = SH_20;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_COEF;
                        cmd.b_sel  = B_M2;
                    end
                    4'd10: begin
                        cmd.acc_op = ACC_SUB;
                        cmd.acc_sh = SH_40;
                        cmd.mul_en = 1'b1;
                        cmd.a_sel  = A_COEF;
                        cmd.b_sel  = B_M3;
                    end
                    4'd11: begin
                        cmd.acc_op = ACC_SUB;
                        cmd.acc_sh = SH_60;
                    end
                    default: begin
                        cmd.acc_op = ACC_HOLD;
                    end
                endcase
            end
            ST_FINISH: begin
                cmd.out_load  = out_free;
                cmd.clr_delay = out_free;
            end
            default: begin
                cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    // A result is never written over a word that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while full");

    // A loaded result is offered in the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not offered");

    // An accepted word always starts the recurrence.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_REC_MUL))
        else $error("accepted word did not start the recurrence");

    // The power step count stays within its sequence.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PWR) |-> (step_reg <= PWR_LAST))
        else $error("power step out of range");

endmodule

// File: src/goertzel_tone_power.sv
// Top level of the Goertzel tone power detector.
//
// Each accepted word carries one signed 16-bit sample, which is run through the
// recurrence s = x + floor(c*s1/2^14) - s2 with the Q2.14 coefficient c written
// on the configuration port (reset value 0). A word without block_end passes
// through one multiply of the coefficient by s1 and one update of the 40-bit
// saturating delay line before the next word can be accepted. For a word with
// block_end, after the update, the shared 40 x 21 multiplier works through 10
// partial products to form s1^2 + s2^2 - floor(c*s1*s2/2^14), which is clamped
// at zero, saturated to 63 bits and placed in the output register, and the delay
// line clears. Further sample words are taken while a finished result waits; a
// second result waits only if the first has not yet been taken.
module goertzel_tone_power import gtp_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic signed [COEF_W-1:0]   cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    input  logic                       s_block_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [POWER_W-1:0]         m_tone_power
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    gtp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    gtp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_sample_value (s_sample_value),
        .s_block_end    (s_block_end),
        .cmd            (cmd),
        .status         (status),
        .m_tone_power   (m_tone_power)
    );

endmodule
